### rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial division prime test
// Holds the default value width, the divisor select code and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_BITS_DEF = 32;

    // Divisor the datapath loads into its remainder unit
    typedef enum logic [1:0] {
        DIV_TWO,
        DIV_THREE,
        DIV_CAND_LO,    // 6k-1
        DIV_CAND_HI     // 6k+1
    } div_sel_t;

    typedef struct packed {
        logic     load;     // latch a new value and reset the candidate
        logic     start;    // begin a remainder computation
        logic     step;     // advance the candidate by six
        div_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic negative;
        logic below_two;
        logic below_four;
        logic busy;         // remainder unit still iterating
        logic rem_zero;
        logic cand_in_range; // candidate squared does not exceed the value
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp: datapath of the trial division prime test
// Holds the value, the 6k-1 candidate and its square, and a restoring
// remainder unit that retires one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_dp #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic signed [VALUE_BITS-1:0] value,
    input  wire tdpt_pkg::dp_cmd_t            cmd,
    output tdpt_pkg::dp_stat_t                stat
);
    import tdpt_pkg::*;

    localparam int NB = VALUE_BITS - 1;     // magnitude bits of a non-negative value
    localparam int SW = VALUE_BITS + 1;     // square of the candidate, with headroom
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] n_reg;
    logic          neg_reg;
    logic [NB-1:0] cand_reg, cand_next;
    logic [SW-1:0] sq_reg, sq_next;

    logic [NB-1:0] div_reg;
    logic [NB-1:0] dvd_reg;
    logic [NB-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg;

    logic [NB-1:0] divisor;
    logic [NB:0]   trial;
    logic [SW-1:0] cand_wide;

    always_comb
    begin
        unique case (cmd.sel)
            DIV_TWO:     divisor = NB'(2);
            DIV_THREE:   divisor = NB'(3);
            DIV_CAND_LO: divisor = cand_reg;
            DIV_CAND_HI: divisor = cand_reg + NB'(2);
            default:     divisor = NB'(2);
        endcase
    end

    // (c+6)^2 = c^2 + 12c + 36
    assign cand_wide = SW'(cand_reg);
    assign cand_next = cand_reg + NB'(6);
    assign sq_next   = sq_reg + (cand_wide << 3) + (cand_wide << 2) + SW'(36);

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[NB-1]};
    always_comb
    begin
        if (trial >= {1'b0, div_reg})
            rem_next = NB'(trial - {1'b0, div_reg});
        else
            rem_next = trial[NB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.start)
            cnt_reg <= CW'(NB);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= value[NB-1:0];
            neg_reg  <= value[VALUE_BITS-1];
            cand_reg <= NB'(5);
            sq_reg   <= SW'(25);
        end
        else if (cmd.step)
        begin
            cand_reg <= cand_next;
            sq_reg   <= sq_next;
        end

        if (cmd.start)
        begin
            div_reg <= divisor;
            dvd_reg <= n_reg;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign stat.negative      = neg_reg;
    assign stat.below_two     = (n_reg < NB'(2));
    assign stat.below_four    = (n_reg < NB'(4));
    assign stat.busy          = (cnt_reg != '0);
    assign stat.rem_zero      = (rem_reg == '0);
    assign stat.cand_in_range = (sq_reg <= SW'(n_reg));

endmodule

`default_nettype wire

### rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl: controller of the trial division prime test
// Sequences the divisions by 2, 3, 6k-1 and 6k+1 and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    prime_flag,
    output logic                    accepted,
    input  wire tdpt_pkg::dp_stat_t stat,
    output tdpt_pkg::dp_cmd_t       cmd
);
    import tdpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_WAIT,
        S_LOOP,
        S_FINISH
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic     prime_reg, prime_next;
    logic     acc_reg, acc_next;
    logic     out_valid_reg, out_valid_next;
    logic     prime_flag_reg, prime_flag_next;
    logic     accepted_reg, accepted_next;

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        prime_next      = prime_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        prime_flag_next = prime_flag_reg;
        accepted_next   = accepted_reg;
        cmd             = '{load: 1'b0, start: 1'b0, step: 1'b0, sel: sel_reg};

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (stat.negative)
                begin
                    prime_next = 1'b0;
                    acc_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else if (stat.below_two)
                begin
                    prime_next = 1'b0;
                    acc_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.below_four)
                begin
                    prime_next = 1'b1;
                    acc_next   = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = DIV_TWO;
                    sel_next   = DIV_TWO;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.busy)
                begin
                    if (stat.rem_zero)
                    begin
                        prime_next = 1'b0;
                        acc_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        unique case (sel_reg)
                            DIV_TWO:
                            begin
                                cmd.start = 1'b1;
                                cmd.sel   = DIV_THREE;
                                sel_next  = DIV_THREE;
                            end
                            DIV_CAND_LO:
                            begin
                                cmd.start = 1'b1;
                                cmd.sel   = DIV_CAND_HI;
                                sel_next  = DIV_CAND_HI;
                            end
                            DIV_CAND_HI:
                            begin
                                cmd.step   = 1'b1;
                                state_next = S_LOOP;
                            end
                            default:
                            begin
                                state_next = S_LOOP;
                            end
                        endcase
                    end
                end
            end
            S_LOOP:
            begin
                if (stat.cand_in_range)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = DIV_CAND_LO;
                    sel_next   = DIV_CAND_LO;
                    state_next = S_WAIT;
                end
                else
                begin
                    prime_next = 1'b1;
                    acc_next   = 1'b0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result slot is free or drains this cycle
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    prime_flag_next = prime_reg;
                    accepted_next   = acc_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= DIV_TWO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg      <= prime_next;
        acc_reg        <= acc_next;
        prime_flag_reg <= prime_flag_next;
        accepted_reg   <= accepted_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign prime_flag = prime_flag_reg;
    assign accepted   = accepted_reg;

endmodule

`default_nettype wire

### rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality classifier by trial division
// Top level joining the sequencing controller and the division datapath.
// ----------------------------------------------------------------------------
// Each item carries one signed value; the block returns one result per item:
// prime_flag when the value is prime, accepted when the value is non-negative
// and not prime. Negative values give neither flag. The value is divided by
// 2, by 3, and then by each pair 6k-1, 6k+1 while (6k-1)^2 does not exceed
// it; the first zero remainder ends the test. Every division runs on a single
// restoring remainder unit that retires one bit per cycle: the cycle that
// starts a division is followed by one restoring step per magnitude bit, and
// the cycle that checks the remainder of 2, or of 6k-1, also starts the next
// division; before each 6k-1/6k+1 pair a bound check takes its own state.
// One item is in work at a time; the result is held in an output register,
// and a new item is taken as soon as the controller is back in idle, which
// it enters with the same edge that loads the result, even while the
// previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              prime_flag,
    output logic                              accepted
);
    import tdpt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: walk the divisor sequence and own the result register
    tdpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .prime_flag (prime_flag),
        .accepted   (accepted),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Datapath: hold the value, the candidate and its square, and divide
    tdpt_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .value (value),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

### test/tb_trial_division_prime_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench for the primality tester
// Drives signed values over a valid/ready input, takes each verdict from the
// directed table or a local trial-division predictor and checks the prime
// and accept flags of every result in order. A short table of corner values
// comes first, then mostly small random values, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test;

    import tdpt_pkg::*;

    localparam int VB = VALUE_BITS_DEF;

    // Slowest legal run: the directed 2^31-1 costs the most, and each of the 75
    // random values up to 2^20 costs far less, plus its share of gaps and
    // stalls. The long hold-off adds more on top of that. The limit allows
    // about four times the sum of these.
    localparam longint CYCLE_LIMIT    = 6_000_000;
    localparam int     RANDOM_ITEMS   = 75;
    localparam int     HOLD_OFF_LEN   = 300;
    localparam int     DRAIN_CYCLES   = 50;
    localparam int     MAX_REPORTED   = 10;

    typedef struct packed {
        bit prime;
        bit acc;
    } verdict_t;

    // One row of the directed table. Where "typed" is set, the verdict is
    // written in by hand; otherwise the predictor supplies it.
    typedef struct packed {
        logic [VB-1:0] v;
        bit            typed;
        bit            prime;
        bit            acc;
    } stim_row_t;

    localparam int N_DIRECTED = 25;

    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // small and special values, read straight off the definition
        '{32'd0,          1'b1, 1'b0, 1'b1},
        '{32'd1,          1'b1, 1'b0, 1'b1},
        '{32'd2,          1'b1, 1'b1, 1'b0},
        '{32'd3,          1'b1, 1'b1, 1'b0},
        '{32'd4,          1'b1, 1'b0, 1'b1},
        // negatives never give a flag
        '{32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0, 1'b0},
        '{32'h8000_0001,  1'b1, 1'b0, 1'b0},
        // largest positive value is the Mersenne prime 2^31-1
        '{32'h7FFF_FFFF,  1'b1, 1'b1, 1'b0},
        '{32'h7FFF_FFFE,  1'b1, 1'b0, 1'b1},
        // first candidates and their squares (loop bound edges)
        '{32'd5,          1'b0, 1'b0, 1'b0},
        '{32'd7,          1'b0, 1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0, 1'b0},
        '{32'd35,         1'b0, 1'b0, 1'b0},
        '{32'd49,         1'b0, 1'b0, 1'b0},
        '{32'd121,        1'b0, 1'b0, 1'b0},
        '{32'd143,        1'b0, 1'b0, 1'b0},
        '{32'd169,        1'b0, 1'b0, 1'b0},
        '{32'd289,        1'b0, 1'b0, 1'b0},
        '{32'd65521,      1'b0, 1'b0, 1'b0},
        '{32'd65535,      1'b0, 1'b0, 1'b0},
        '{32'd1000003,    1'b0, 1'b0, 1'b0},
        // alternating bit patterns, both fall out on small divisors
        '{32'h5555_5555,  1'b0, 1'b0, 1'b0},
        '{32'h2AAA_AAAA,  1'b0, 1'b0, 1'b0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [VB-1:0] value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 prime_flag;
    logic                 accepted;

    verdict_t pending_verdicts [$];

    int     mismatch_count;
    int     results_seen;
    int     primes_sent;
    int     negatives_sent;
    longint cycle_count;

    // Shared knobs: burst drops the idle gaps on both sides, hold_off_req asks
    // the receiver for one long stall.
    bit burst;
    bit hold_off_req;

    trial_division_prime_test #(
        .VALUE_BITS (VB)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .prime_flag (prime_flag),
        .accepted   (accepted)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Trial division by 2, 3 and then 6k-1 / 6k+1 while d*d <= n.
    function automatic bit trial_divide(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if ((n % 2) == 0 || (n % 3) == 0)
            return 1'b0;
        for (d = 5; d <= n / d; d += 6)
        begin
            if ((n % d) == 0 || (n % (d + 2)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Classify one value at the block's width; the top bit is the sign.
    function automatic verdict_t classify(input logic [VB-1:0] v);
        verdict_t res;
        bit       negative;
        negative  = v[VB-1];
        res.prime = negative ? 1'b0 : trial_divide(longint'(v));
        res.acc   = !negative && !res.prime;
        return res;
    endfunction

    // Offer one item: idle for a random gap, then hold valid until taken.
    // Valid from the previous item is lowered only when a gap follows, so
    // back-to-back items never see a low and a high in the same step.
    task automatic offer_value(input logic [VB-1:0] v, input bit typed,
                               input verdict_t typed_verdict);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        // Item taken at this edge: queue its expected verdict.
        pending_verdicts.push_back(typed ? typed_verdict : classify(v));
        if (v[VB-1])
            negatives_sent++;
        else if (classify(v).prime)
            primes_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input verdict_t exp);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("[%0t] %s: expected prime=%0b acc=%0b, got prime=%0b acc=%0b",
                     $time, what, exp.prime, exp.acc, prime_flag, accepted);
    endtask

    // Receiver: stall a random number of cycles before each result, or a long
    // stretch when asked, then hold ready until one result is taken.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                stall        = HOLD_OFF_LEN;
                hold_off_req = 1'b0;
            end
            else
                stall = burst ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // Check every taken result against the oldest pending verdict.
    always @(posedge clk)
    begin
        verdict_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                exp = '0;
                report_mismatch("unexpected result", exp);
            end
            else
            begin
                exp = pending_verdicts.pop_front();
                if (prime_flag !== exp.prime || accepted !== exp.acc)
                    report_mismatch("flag mismatch", exp);
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [VB-1:0] rnd;
        verdict_t      typed_verdict;
        int            pick;

        mismatch_count = 0;
        results_seen   = 0;
        primes_sent    = 0;
        negatives_sent = 0;
        cycle_count    = 0;
        burst          = 1'b0;
        hold_off_req   = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;

        // Hold reset, then release it on a falling edge.
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (DIRECTED_ROWS[i])
        begin
            typed_verdict.prime = DIRECTED_ROWS[i].prime;
            typed_verdict.acc   = DIRECTED_ROWS[i].acc;
            offer_value(DIRECTED_ROWS[i].v, DIRECTED_ROWS[i].typed, typed_verdict);
        end

        // Pause the input until every directed result has come back.
        drop_valid();
        while (pending_verdicts.size() != 0)
            @(posedge clk);

        // Random values: a fifth negative over the full range, the rest
        // mostly below 2^16, a few up to 2^20 to keep the run short.
        typed_verdict = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Ask for a long output stall while small items keep coming, so
            // the block fills and backs up its input.
            if (n == 30)
                hold_off_req = 1'b1;
            // Run a stretch with no idling on either side.
            burst = (n >= 60 && n < 80);

            pick = $urandom_range(0, 99);
            if (pick < 20)
                rnd = $urandom() | (32'h1 << (VB - 1));
            else if (pick < 30)
                rnd = $urandom_range(0, 16);
            else if (pick < 90)
                rnd = $urandom_range(0, 65535);
            else
                rnd = $urandom_range(0, (1 << 20) - 1);
            offer_value(rnd, 1'b0, typed_verdict);
        end
        burst = 1'b0;
        drop_valid();

        // Drain, then watch a little longer for stray results.
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d directed and %0d random items, %0d results checked,",
                 N_DIRECTED, RANDOM_ITEMS, results_seen);
        $display("including %0d primes and %0d negatives, with a long output stall.",
                 primes_sent, negatives_sent);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
        begin
            $display("%0d mismatches in total", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/tdpt_pkg.sv
rtl/tdpt_dp.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_prime_test.sv
test/tb_trial_division_prime_test.sv
